// ===== hw/rtl/gtlm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtlm_pkg
// shared constants, types and rom builders for the local mercator core
// ----------------------------------------------------------------------------
package gtlm_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int MUL_LAT = 4;

  localparam logic signed [30:0] LAT_LIMIT = 31'sd850511288;
  localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
  localparam logic signed [63:0] PI_Q61 = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] QUARTER_PI = PI_Q61 >>> 3;
  localparam logic signed [63:0] R_MM = 64'sd6378137000;
  localparam logic signed [63:0] DEG7_DIV = 64'sd1800000000;
  localparam logic signed [63:0] HALF_MM_Q20 = 64'sd1 <<< 19;
  localparam logic signed [63:0] LN_FLOOR = ONE_Q60 >>> 5;
  localparam logic signed [63:0] Y0_Q60 = (ONE_Q60 / 5) * 3;

  // degrees*1e7 to radians, q92
  localparam logic signed [63:0] RAD_Q1 = PI_Q61 / DEG7_DIV;
  localparam logic signed [63:0] RAD_R1 = PI_Q61 % DEG7_DIV;
  localparam logic signed [63:0] RAD_Q92 = (RAD_Q1 <<< 31) + ((RAD_R1 <<< 31) / DEG7_DIV);

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } rot_t;

  // mantissa in [0.5,1], accumulated log table sum, exponent code (e + 4)
  typedef struct packed {
    logic [60:0] m;
    logic [60:0] acc;
    logic [2:0]  sh;
  } lnv_t;

  typedef struct packed {
    logic [36:0] east;
    logic [36:0] north;
    logic [27:0] up;
    logic        hit;
  } res_t;

  // bitwise restoring divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] mulq_c(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int s);
    logic neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] r;
    logic [127:0] prod;
    neg = a[63] ^ b[63];
    ua = a[63] ? (~a + 64'd1) : a;
    ub = b[63] ? (~b + 64'd1) : b;
    prod = {64'd0, ua} * {64'd0, ub};
    r = 64'(prod >> s);
    return neg ? (~r + 64'd1) : r;
  endfunction

  function automatic logic signed [63:0] atan_val(input int k);
    logic signed [63:0] sa;
    logic signed [63:0] t;
    sa = '0;
    if (k == 0) begin
      sa = QUARTER_PI;
    end else begin
      for (int n = 1; k * n < 60; n++) begin
        t = udiv64(64'(ONE_Q60 >>> (k * n)), 64'(n));
        if (n[0]) begin
          if (n[1]) sa = sa - t;
          else sa = sa + t;
        end
      end
    end
    return sa;
  endfunction

  function automatic logic signed [63:0] lnp_val(input int k);
    logic signed [63:0] sl;
    logic signed [63:0] t;
    sl = '0;
    for (int n = 1; k * n < 60; n++) begin
      t = udiv64(64'(ONE_Q60 >>> (k * n)), 64'(n));
      if (n[0]) sl = sl + t;
      else sl = sl - t;
    end
    return sl;
  endfunction

  function automatic logic signed [63:0] ln2_val();
    logic signed [63:0] s;
    s = '0;
    for (int n = 1; n < 60; n++) begin
      s = s + udiv64(64'(ONE_Q60 >>> n), 64'(n));
    end
    return s;
  endfunction

  // reciprocal of the cordic gain by newton steps
  function automatic logic signed [63:0] inv_gain(input int stages);
    logic signed [63:0] p;
    logic signed [63:0] y;
    logic signed [63:0] t;
    p = ONE_Q60;
    for (int k = 0; k < stages; k++) begin
      p = p + (p >>> (2 * k));
    end
    y = Y0_Q60;
    for (int i = 0; i < 12; i++) begin
      t = 3 * ONE_Q60 - mulq_c(p, mulq_c(y, y, 60), 60);
      y = mulq_c(y, t, 61);
    end
    return y;
  endfunction

  localparam logic signed [63:0] LN2_Q60 = ln2_val();

  // (e + 1) * ln2 indexed by exponent code e + 4
  localparam logic signed [63:0] LN2_MUL [8] = '{
    -3 * LN2_Q60, -2 * LN2_Q60, -1 * LN2_Q60, 64'sd0,
    LN2_Q60, 2 * LN2_Q60, 3 * LN2_Q60, 4 * LN2_Q60
  };

endpackage

// ===== hw/rtl/gtlm_delay.sv =====
// ----------------------------------------------------------------------------
// gtlm_delay
// enabled shift line that keeps side data in step with the pipe
// ----------------------------------------------------------------------------
module gtlm_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== hw/rtl/gtlm_mul.sv =====
// ----------------------------------------------------------------------------
// gtlm_mul
// 64x64 signed multiply, shifted and truncated toward zero, four stages
// ----------------------------------------------------------------------------
module gtlm_mul #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic         neg1;
  logic         neg2;
  logic         neg3;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic [127:0] sum;
  logic [63:0]  r;

  assign r = sum[SHIFT +: 64];

  always_ff @(posedge clk) begin
    if (en) begin
      // sign and magnitude
      neg1 <= a[63] ^ b[63];
      ua   <= a[63] ? (~a + 64'd1) : a;
      ub   <= b[63] ? (~b + 64'd1) : b;
      // partial products
      neg2 <= neg1;
      p00  <= ua[31:0] * ub[31:0];
      p01  <= ua[31:0] * ub[63:32];
      p10  <= ua[63:32] * ub[31:0];
      p11  <= ua[63:32] * ub[63:32];
      // combine
      neg3 <= neg2;
      sum  <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
      // shift and restore sign
      p    <= neg3 ? (~r + 64'd1) : r;
    end
  end

endmodule

// ===== hw/rtl/gtlm_rot_cell.sv =====
// ----------------------------------------------------------------------------
// gtlm_rot_cell
// one rotation-mode cordic step
// ----------------------------------------------------------------------------
module gtlm_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                en,
  input  gtlm_pkg::rot_t      d,
  output gtlm_pkg::rot_t      q
);

  localparam logic signed [63:0] ATAN = gtlm_pkg::atan_val(STAGE);

  logic signed [63:0] dx;
  logic signed [63:0] dy;

  assign dx = d.y >>> STAGE;
  assign dy = d.x >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d.z[63]) begin
        q.x <= d.x - dx;
        q.y <= d.y + dy;
        q.z <= d.z - ATAN;
      end else begin
        q.x <= d.x + dx;
        q.y <= d.y - dy;
        q.z <= d.z + ATAN;
      end
    end
  end

endmodule

// ===== hw/rtl/gtlm_ln_cell.sv =====
// ----------------------------------------------------------------------------
// gtlm_ln_cell
// one shift-add logarithm step, multiplies by (1 + 2^-k) while it fits
// ----------------------------------------------------------------------------
module gtlm_ln_cell #(
  parameter int STAGE = 1
) (
  input  logic            clk,
  input  logic            en,
  input  gtlm_pkg::lnv_t  d,
  output gtlm_pkg::lnv_t  q
);

  localparam logic [60:0] LNP = 61'(gtlm_pkg::lnp_val(STAGE));
  localparam logic [61:0] ONE = 62'(gtlm_pkg::ONE_Q60);

  logic [61:0] t;

  assign t = {1'b0, d.m} + {1'b0, d.m >> STAGE};

  always_ff @(posedge clk) begin
    if (en) begin
      q.sh <= d.sh;
      if (t <= ONE) begin
        q.m   <= t[60:0];
        q.acc <= d.acc + LNP;
      end else begin
        q.m   <= d.m;
        q.acc <= d.acc;
      end
    end
  end

endmodule

// ===== hw/rtl/gps_to_local_mercator_core.sv =====
// ----------------------------------------------------------------------------
// gps_to_local_mercator_core
// gnss fix to local east/north/up in mm, spherical mercator scaled by the
// cosine of the reference latitude
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    latitude, longitude, altitude
//  m_axis    out  m_axis_tvalid/m_axis_tready    east, north, up; tuser=clamp flag
//  cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
//  one fix per cycle while the skid register is empty; pipe depth is set by
//  the cordic and log cell chains plus the four-stage 64-bit multipliers at
//  both ends
//  reset clears the valid bits and both reference registers; no clearing pass
//  a waiting output beat holds in the output register while the pipe keeps
//  going; one more result lands in a skid register, then the pipe freezes
//  cfg is always ready; the user must write only while nothing is in flight, the core does not enforce it
//
module gps_to_local_mercator_core #(
  parameter int CORDIC_STAGES = gtlm_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // latitude[30:0], longitude[62:31], altitude[90:63]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // east_offset[36:0], north_offset[73:37], up_offset[101:74]
  output logic         m_axis_tuser,   // lat_clamped[0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int N          = CORDIC_STAGES;
  localparam int ML         = gtlm_pkg::MUL_LAT;
  localparam int SCALE_DLY  = N + 4;
  localparam int EAST_DLY   = 2 * N + 5;
  localparam int SIDE_DLY   = 2 * N + 5 + 3 * ML;
  localparam logic signed [63:0] INV_K = gtlm_pkg::inv_gain(CORDIC_STAGES);

  localparam logic [1:0] CFG_REF_LAT = 2'd0;
  localparam logic [1:0] CFG_REF_LON = 2'd1;

  // reference point registers
  logic [30:0] ref_latitude;
  logic [31:0] ref_longitude;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude  <= '0;
      ref_longitude <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REF_LAT: ref_latitude  <= cfg_data[30:0];
        CFG_REF_LON: ref_longitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the skid register is holding a result
  logic en;
  logic out_valid;
  logic skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // input stage: clamp both latitudes, full-width longitude difference
  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic signed [30:0] rlat_raw;
  logic signed [30:0] lat_c;
  logic signed [30:0] rlat_c;
  logic               lat_hit;

  assign in_lat   = s_axis_tdata[30:0];
  assign in_lon   = s_axis_tdata[62:31];
  assign rlat_raw = ref_latitude;

  always_comb begin
    lat_hit = 1'b0;
    lat_c   = in_lat;
    if (in_lat > gtlm_pkg::LAT_LIMIT) begin
      lat_c   = gtlm_pkg::LAT_LIMIT;
      lat_hit = 1'b1;
    end else if (in_lat < -gtlm_pkg::LAT_LIMIT) begin
      lat_c   = -gtlm_pkg::LAT_LIMIT;
      lat_hit = 1'b1;
    end
    rlat_c = rlat_raw;
    if (rlat_raw > gtlm_pkg::LAT_LIMIT) rlat_c = gtlm_pkg::LAT_LIMIT;
    else if (rlat_raw < -gtlm_pkg::LAT_LIMIT) rlat_c = -gtlm_pkg::LAT_LIMIT;
  end

  logic               s0_valid;
  logic               s0_hit;
  logic signed [30:0] s0_lat;
  logic signed [30:0] s0_rlat;
  logic signed [32:0] s0_dlon;
  logic [27:0]        s0_alt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_hit  <= lat_hit;
      s0_lat  <= lat_c;
      s0_rlat <= rlat_c;
      s0_dlon <= {in_lon[31], in_lon} - {ref_longitude[31], ref_longitude};
      s0_alt  <= s_axis_tdata[90:63];
    end
  end

  // degrees to radians
  logic signed [63:0] lat_rad;
  logic signed [63:0] rlat_rad;
  logic signed [63:0] dlon_rad;

  gtlm_mul #(.SHIFT(32)) u_mul_lat (
    .clk(clk), .en(en), .a({{33{s0_lat[30]}}, s0_lat}), .b(gtlm_pkg::RAD_Q92), .p(lat_rad)
  );
  gtlm_mul #(.SHIFT(32)) u_mul_rlat (
    .clk(clk), .en(en), .a({{33{s0_rlat[30]}}, s0_rlat}), .b(gtlm_pkg::RAD_Q92), .p(rlat_rad)
  );
  gtlm_mul #(.SHIFT(32)) u_mul_dlon (
    .clk(clk), .en(en), .a({{31{s0_dlon[32]}}, s0_dlon}), .b(gtlm_pkg::RAD_Q92), .p(dlon_rad)
  );

  // cordic lanes: 0 = cos of reference, 1 = fix mercator angle, 2 = reference mercator angle
  gtlm_pkg::rot_t b_rot [3];
  gtlm_pkg::rot_t rot_s [3][N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      b_rot[0] <= '{x: gtlm_pkg::ONE_Q60, y: 64'sd0, z: rlat_rad};
      b_rot[1] <= '{x: gtlm_pkg::ONE_Q60, y: 64'sd0,
                    z: gtlm_pkg::QUARTER_PI + (lat_rad >>> 1)};
      b_rot[2] <= '{x: gtlm_pkg::ONE_Q60, y: 64'sd0,
                    z: gtlm_pkg::QUARTER_PI + (rlat_rad >>> 1)};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_rot_lane
    assign rot_s[l][0] = b_rot[l];
    for (genvar c = 0; c < N; c++) begin : g_rot_cell
      gtlm_rot_cell #(.STAGE(c)) u_cell (
        .clk(clk), .en(en), .d(rot_s[l][c]), .q(rot_s[l][c+1])
      );
    end
  end

  // scale = cos(ref lat), gain removed, held until the final multiply
  logic signed [63:0] scale_raw;
  logic [63:0]        scale_q;

  gtlm_mul #(.SHIFT(60)) u_mul_gain (
    .clk(clk), .en(en), .a(rot_s[0][N].x), .b(INV_K), .p(scale_raw)
  );

  gtlm_delay #(.W(64), .DEPTH(SCALE_DLY)) u_dly_scale (
    .clk(clk), .rst(rst), .en(en), .d(scale_raw), .q(scale_q)
  );

  // log lanes: ln y and ln x of both mercator rotations
  logic signed [63:0] ln_in [4];
  gtlm_pkg::lnv_t     ln_n  [4];
  gtlm_pkg::lnv_t     ln_s  [4][N+1];
  logic signed [63:0] ln_r  [4];

  assign ln_in[0] = rot_s[1][N].y;
  assign ln_in[1] = rot_s[1][N].x;
  assign ln_in[2] = rot_s[2][N].y;
  assign ln_in[3] = rot_s[2][N].x;

  for (genvar l = 0; l < 4; l++) begin : g_ln_lane
    logic signed [63:0] v;
    logic [2:0]         sh;
    logic [63:0]        mv;

    // floor at 1/32, then leading one lands in bits 62..55
    always_comb begin
      v = (ln_in[l] < gtlm_pkg::LN_FLOOR) ? gtlm_pkg::LN_FLOOR : ln_in[l];
      sh = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (v[55+i]) sh = 3'(i);
      end
      case (sh)
        3'd0:    mv = v <<< 4;
        3'd1:    mv = v <<< 3;
        3'd2:    mv = v <<< 2;
        3'd3:    mv = v <<< 1;
        3'd4:    mv = v;
        3'd5:    mv = v >>> 1;
        3'd6:    mv = v >>> 2;
        default: mv = v >>> 3;
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ln_n[l] <= '{m: mv[60:0], acc: 61'd0, sh: sh};
      end
    end

    assign ln_s[l][0] = ln_n[l];
    for (genvar c = 0; c < N; c++) begin : g_ln_cell
      gtlm_ln_cell #(.STAGE(c + 1)) u_cell (
        .clk(clk), .en(en), .d(ln_s[l][c]), .q(ln_s[l][c+1])
      );
    end

    // (m - 1) - sum + (e + 1) ln2
    always_ff @(posedge clk) begin
      if (en) begin
        ln_r[l] <= $signed({3'b0, ln_s[l][N].m}) - gtlm_pkg::ONE_Q60
                   - $signed({3'b0, ln_s[l][N].acc}) + gtlm_pkg::LN2_MUL[ln_s[l][N].sh];
      end
    end
  end

  // north angle difference
  logic signed [63:0] merc_fix;
  logic signed [63:0] merc_ref;
  logic signed [63:0] north_rad;

  always_ff @(posedge clk) begin
    if (en) begin
      merc_fix  <= ln_r[0] - ln_r[1];
      merc_ref  <= ln_r[2] - ln_r[3];
      north_rad <= merc_fix - merc_ref;
    end
  end

  // longitude difference waits for the north path
  logic [63:0] east_rad;

  gtlm_delay #(.W(64), .DEPTH(EAST_DLY)) u_dly_east (
    .clk(clk), .rst(rst), .en(en), .d(dlon_rad), .q(east_rad)
  );

  // radians to mm q20, then scale
  logic signed [63:0] d_east;
  logic signed [63:0] d_north;
  logic signed [63:0] s_east;
  logic signed [63:0] s_north;

  gtlm_mul #(.SHIFT(40)) u_mul_re (
    .clk(clk), .en(en), .a(east_rad), .b(gtlm_pkg::R_MM), .p(d_east)
  );
  gtlm_mul #(.SHIFT(40)) u_mul_rn (
    .clk(clk), .en(en), .a(north_rad), .b(gtlm_pkg::R_MM), .p(d_north)
  );
  gtlm_mul #(.SHIFT(60)) u_mul_se (
    .clk(clk), .en(en), .a(d_east), .b(scale_q), .p(s_east)
  );
  gtlm_mul #(.SHIFT(60)) u_mul_sn (
    .clk(clk), .en(en), .a(d_north), .b(scale_q), .p(s_north)
  );

  // valid, clamp flag and altitude ride alongside
  logic [29:0] side_q;

  gtlm_delay #(.W(30), .DEPTH(SIDE_DLY)) u_dly_side (
    .clk(clk), .rst(rst), .en(en), .d({s0_valid, s0_hit, s0_alt}), .q(side_q)
  );

  // round half up to whole mm
  logic signed [63:0] east_rnd;
  logic signed [63:0] north_rnd;
  logic               h_valid;
  gtlm_pkg::res_t     h_res;

  assign east_rnd  = s_east + gtlm_pkg::HALF_MM_Q20;
  assign north_rnd = s_north + gtlm_pkg::HALF_MM_Q20;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= side_q[29];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_res <= '{east: east_rnd[56:20], north: north_rnd[56:20],
                 up: side_q[27:0], hit: side_q[28]};
    end
  end

  // output register plus skid register
  gtlm_pkg::res_t out_res;
  gtlm_pkg::res_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else if (en && h_valid) begin
          out_res <= h_res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (en && h_valid) begin
          out_res   <= h_res;
          out_valid <= 1'b1;
        end
      end else if (en && h_valid) begin
        skid_res   <= h_res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.up, out_res.north, out_res.east};
  assign m_axis_tuser  = out_res.hit;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid filled without a stalled output beat");

  a_cfg_lat_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == CFG_REF_LAT)
      |=> ref_latitude == $past(cfg_data[30:0]))
    else $error("reference latitude write lost");
`endif

endmodule

// ===== tb/gps_to_local_mercator_checker.sv =====
// ----------------------------------------------------------------------------
// gps_to_local_mercator_checker
// watches the fix, result and register channels of the local mercator core,
// works out each expected east/north/up beat in fixed point and compares
// ----------------------------------------------------------------------------
module gps_to_local_mercator_checker #(
  parameter int STAGES = gtlm_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_REF_LAT = 0;
  localparam int REG_REF_LON = 1;
  localparam longint LIMIT = 850511288;
  localparam longint UNIT = 64'sd1 <<< 60;

  typedef struct {
    logic [36:0] east;
    logic [36:0] north;
    logic [27:0] up;
    logic        hit;
  } offsets_t;

  longint atan_rom [0:48];
  longint lnp_rom [0:48];
  longint ln2_c, inv_gain_c, rad_c;
  logic [30:0] ref_lat;
  logic [31:0] ref_lon;
  offsets_t offsets_q[$];
  int n_checked;

  function automatic longint mul_shift(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0] ua, ub, r;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    r = 64'(p >> s);
    return neg ? -r : r;
  endfunction

  initial begin
    longint sa, sl, t, p, y;
    atan_rom[0] = 64'sh6487ED5110B4611A >>> 3;
    lnp_rom[0] = 0;
    for (int k = 1; k <= 48; k++) begin
      sa = 0;
      sl = 0;
      for (int n = 1; k * n < 60; n++) begin
        t = (UNIT >>> (k * n)) / n;
        if (n % 2 == 1) begin
          sl += t;
          if ((n / 2) % 2 == 1) sa -= t;
          else sa += t;
        end else begin
          sl -= t;
        end
      end
      atan_rom[k] = sa;
      lnp_rom[k] = sl;
    end
    ln2_c = 0;
    for (int n = 1; n < 60; n++) ln2_c += (UNIT >>> n) / n;
    p = UNIT;
    for (int k = 0; k < STAGES; k++) p += p >>> (2 * k);
    // newton iteration for 1/sqrt of the gain product
    y = (UNIT / 5) * 3;
    for (int i = 0; i < 12; i++) begin
      t = 3 * UNIT - mul_shift(p, mul_shift(y, y, 60), 60);
      y = mul_shift(y, t, 61);
    end
    inv_gain_c = y;
    rad_c = gtlm_pkg::RAD_Q92;
  end

  function automatic void rotate(input longint z, output longint xo, output longint yo);
    longint x, y, dx, dy;
    x = UNIT;
    y = 0;
    for (int k = 0; k < STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_rom[k];
      end else begin
        x += dx; y -= dy; z += atan_rom[k];
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic longint log_fx(longint v);
    int p, e;
    longint m, acc, t;
    acc = 0;
    if (v < (UNIT >>> 5)) v = UNIT >>> 5;
    p = 62;
    while (p > 0 && v[p] == 1'b0) p--;
    e = p - 59;
    m = e > 0 ? v >>> e : v << (-e);
    for (int k = 1; k <= STAGES; k++) begin
      t = m + (m >>> k);
      if (t <= UNIT) begin
        m = t;
        acc += lnp_rom[k];
      end
    end
    return (m - UNIT) - acc + longint'(e + 1) * ln2_c;
  endfunction

  function automatic longint to_rad(longint deg7);
    return mul_shift(deg7, rad_c, 32);
  endfunction

  function automatic longint mercator_y(longint phi);
    longint x, y;
    rotate((64'sh6487ED5110B4611A >>> 3) + (phi >>> 1), x, y);
    return log_fx(y) - log_fx(x);
  endfunction

  function automatic logic [36:0] to_mm(longint rad, longint scale);
    longint d, s;
    d = mul_shift(rad, 64'sd6378137000, 40);
    s = mul_shift(d, scale, 60);
    return 37'((s + (64'sd1 <<< 19)) >>> 20);
  endfunction

  function automatic offsets_t project_fix(logic [95:0] fix);
    offsets_t o;
    longint lat, rlat, dlon, cx, cy, scale;
    lat = longint'(signed'(fix[30:0]));
    o.hit = 1'b0;
    if (lat > LIMIT) begin lat = LIMIT; o.hit = 1'b1; end
    if (lat < -LIMIT) begin lat = -LIMIT; o.hit = 1'b1; end
    // reference latitude is clamped silently
    rlat = longint'(signed'(ref_lat));
    if (rlat > LIMIT) rlat = LIMIT;
    if (rlat < -LIMIT) rlat = -LIMIT;
    // full-width longitude difference, no wrap at the antimeridian
    dlon = longint'(signed'(fix[62:31])) - longint'(signed'(ref_lon));
    rotate(to_rad(rlat), cx, cy);
    scale = mul_shift(cx, inv_gain_c, 60);
    o.east = to_mm(to_rad(dlon), scale);
    o.north = to_mm(mercator_y(to_rad(lat)) - mercator_y(to_rad(rlat)), scale);
    o.up = fix[90:63];
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch beat %0d %s: got %0h want %0h", n_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    offsets_t w;
    if (rst) begin
      ref_lat <= '0;
      ref_lon <= '0;
      offsets_q.delete();
      mismatches = 0;
      n_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REF_LAT) ref_lat <= cfg_data[30:0];
        else if (cfg_index == REG_REF_LON) ref_lon <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) offsets_q.push_back(project_fix(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (offsets_q.size() == 0) begin
          report("unexpected beat", m_axis_tdata[63:0], 0);
        end else begin
          w = offsets_q.pop_front();
          if (m_axis_tdata[36:0] !== w.east) report("east", m_axis_tdata[36:0], w.east);
          if (m_axis_tdata[73:37] !== w.north) report("north", m_axis_tdata[73:37], w.north);
          if (m_axis_tdata[101:74] !== w.up) report("up", m_axis_tdata[101:74], w.up);
          if (m_axis_tuser !== w.hit) report("clamp flag", m_axis_tuser, w.hit);
        end
        n_checked++;
      end
    end
    pending = offsets_q.size();
  end

endmodule

// ===== tb/gps_to_local_mercator_core_tb.sv =====
// ----------------------------------------------------------------------------
// gps_to_local_mercator_core_tb
// drives fixes and reference points into the local mercator core under
// several idle/stall mixes and a long output hold-off; the checker predicts
// ----------------------------------------------------------------------------
module gps_to_local_mercator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_REF_LAT = 0;
  localparam int REG_REF_LON = 1;
  localparam int PIPE_LAT = 2 * gtlm_pkg::CORDIC_STAGES_DEF + 20;
  localparam longint LIMIT = 850511288;
  localparam int HOLD_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // latitude[30:0], longitude[62:31], altitude[90:63]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // east[36:0], north[73:37], up[101:74]
  logic         m_axis_tuser;        // lat_clamped[0]
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int mismatches, pending;
  int send_idle_pct = 0;   // sender gap chance per cycle
  int recv_stall_pct = 0;  // receiver stall chance per cycle
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int n_fixes = 0;
  int n_refs = 0;

  always #4 clk = ~clk;

  gps_to_local_mercator_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gps_to_local_mercator_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // one fix beat; random gaps before it, tvalid stays high between beats
  task automatic send_fix(input longint lat, input longint lon, input longint alt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, alt[27:0], lon[31:0], lat[30:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_fixes++;
  endtask

  // drain everything in flight, then let the pipe settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // cfg_valid stays high after the beat; the caller drops it
  task automatic write_reg(input int idx, input longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_data <= value[31:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_reference(input longint rlat, input longint rlon);
    drain();
    write_reg(REG_REF_LAT, rlat);
    write_reg(REG_REF_LON, rlon);
    cfg_valid <= 1'b0;
    n_refs++;
  endtask

  // mostly in-range fixes, some near the clamp limit and at the poles
  task automatic random_fixes(input int count);
    longint lat, lon, alt;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: lat = ($urandom_range(1) ? 1 : -1) * (LIMIT - 50 + $urandom_range(100));
        1: lat = ($urandom_range(1) ? 1 : -1) * (LIMIT + $urandom_range(49488712));
        default: lat = longint'($urandom_range(1800000000)) - 900000000;
      endcase
      lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
      alt = longint'($urandom_range(101000000)) - 1000000;
      send_fix(lat, lon, alt);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, both clamp sides, reference at reset values
    send_fix(0, 0, 0);
    send_fix(900000000, 1800000000, 100000000);
    send_fix(-900000000, -1800000000, -1000000);
    send_fix(LIMIT, 1, 1);
    send_fix(-LIMIT, -1, -1);
    send_fix(LIMIT + 1, 0, 0);
    send_fix(-LIMIT - 1, 0, 0);
    send_fix(LIMIT - 1, 1800000000, 0);
    send_fix(-LIMIT + 1, -1800000000, 0);
    send_fix(1, -1, 12345);
    // reference at the far corner so the longitude difference spans 33 bits
    set_reference(LIMIT, 1800000000);
    send_fix(-900000000, -1800000000, 100000000);
    send_fix(0, 0, -1000000);
    send_fix(LIMIT, 1800000000, 0);
    set_reference(-LIMIT, -1800000000);
    send_fix(900000000, 1800000000, 0);
    send_fix(-LIMIT, -1800000000, 7);
    // reference beyond the limit is clamped silently
    set_reference(31'sh3FFFFFFF, 32'h7FFFFFFF);
    send_fix(123456789, 5, 0);
    set_reference(-31'sh40000000, 32'h80000000);
    send_fix(-123456789, -5, 0);

    // random phases: each idle mix under a few reference points
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 22 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 22 : 0;
      set_reference(longint'($urandom_range(1701022576)) - LIMIT,
                    longint'($urandom_range(32'd3600000000)) - 1800000000);
      if (ph == 0) begin
        // long hold-off while the sender keeps offering, to fill the pipe
        hold_req <= 1'b1;
        random_fixes(200);
      end
      random_fixes(190);
      set_reference(ph[0] ? LIMIT : -LIMIT, ph[1] ? 1800000000 : -1800000000);
      random_fixes(170);
    end
    drain();

    $display("covered %0d fixes over %0d reference points", n_fixes, n_refs);
    $display("idle mixes none/sender/receiver/both, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
